[sv/acd_pkg.sv]
`timescale 1ns / 1ps

package acd_pkg;

    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned MAG_W      = 16;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned AVG_W      = 33;   // Q17.16
    localparam int unsigned THR_W      = 16;   // Q8.8
    localparam int unsigned WEIGHT_W   = 5;
    localparam int unsigned NUM_W      = 38;   // k*mag<<16 + (N-k)*avg
    localparam int unsigned FRAC_W     = 16;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd282;
    localparam logic [MAG_W-1:0] MAG_MAX         = 16'd56755;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic             crash_flag;
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] average_whole;
    } result_t;

endpackage

[sv/acd_front.sv]
`timescale 1ns / 1ps

module acd_front
    import acd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  sample_t          sample,
    output logic             push,
    input  logic             full,
    output logic [MAG_W-1:0] push_mag
);

    typedef enum logic [1:0] {
        IDLE,
        SQUARE,
        ROOT,
        PUSH
    } state_t;

    state_t                  state_reg;
    logic [AXIS_W:0]         abs_x_reg, abs_y_reg, abs_z_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [MAG_W+1:0]        rem_reg;
    logic [MAG_W-1:0]        root_reg;
    logic [3:0]              cnt_reg;

    logic [2*AXIS_W+1:0]     sq_sum;
    logic [MAG_W+3:0]        rem_sh;
    logic [MAG_W+3:0]        trial;
    logic                    fits;

    function automatic logic [AXIS_W:0] abs17(input logic signed [AXIS_W-1:0] v);
        logic signed [AXIS_W:0] e;
        e = {v[AXIS_W-1], v};
        return e[AXIS_W] ? $unsigned(-e) : $unsigned(e);
    endfunction

    always_comb
    begin
        sq_sum = (2*AXIS_W+2)'(abs_x_reg * abs_x_reg)
               + (2*AXIS_W+2)'(abs_y_reg * abs_y_reg)
               + (2*AXIS_W+2)'(abs_z_reg * abs_z_reg);
        rem_sh = {rem_reg, sum_reg[SUM_W-1 -: 2]};
        trial  = (MAG_W+4)'({root_reg, 2'b01});
        fits   = (rem_sh >= trial);
    end

    assign sample_stall = (state_reg != IDLE);
    assign push         = (state_reg == PUSH) && !full;
    assign push_mag     = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (sample_valid)
                    begin
                        abs_x_reg <= abs17(sample.accel_x);
                        abs_y_reg <= abs17(sample.accel_y);
                        abs_z_reg <= abs17(sample.accel_z);
                        state_reg <= SQUARE;
                    end
                end
                SQUARE:
                begin
                    sum_reg   <= sq_sum[SUM_W-1:0];   // at most 3*2^30
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ROOT;
                end
                ROOT:
                begin
                    // one root bit per cycle, two radicand bits consumed
                    sum_reg <= {sum_reg[SUM_W-3:0], 2'b00};
                    if (fits)
                    begin
                        rem_reg  <= (MAG_W+2)'(rem_sh - trial);
                        root_reg <= {root_reg[MAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh[MAG_W+1:0];
                        root_reg <= {root_reg[MAG_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(MAG_W - 1))
                    begin
                        state_reg <= PUSH;
                    end
                end
                PUSH:
                begin
                    if (!full)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

[sv/acd_fifo.sv]
`timescale 1ns / 1ps

module acd_fifo
    import acd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [MAG_W-1:0] push_mag,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [MAG_W-1:0] pop_mag
);

    logic [MAG_W-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_mag = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

[sv/acd_back.sv]
`timescale 1ns / 1ps

module acd_back
    import acd_pkg::*;
#(
    parameter int unsigned SETTLE_SAMPLES = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  logic [MAG_W-1:0] pop_mag,
    output logic             pop,
    input  logic [THR_W-1:0] threshold,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result
);

    localparam int unsigned DIV_SHIFT = NUM_W + $clog2(SETTLE_SAMPLES);
    localparam int unsigned RECIP_W   = NUM_W + 1;
    localparam int unsigned ACC_W     = NUM_W + RECIP_W;
    localparam int unsigned A_LO_W    = NUM_W / 2;
    localparam int unsigned A_HI_W    = NUM_W - A_LO_W;
    localparam int unsigned R_HI_W    = RECIP_W / 2;
    localparam int unsigned R_LO_W    = RECIP_W - R_HI_W;
    localparam int unsigned PP_W      = A_HI_W + R_LO_W;
    localparam logic [WEIGHT_W-1:0] N_VAL = WEIGHT_W'(SETTLE_SAMPLES);
    // ceil(2^DIV_SHIFT / N) gives the exact floor quotient for any NUM_W-bit numerator
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT)
        + 64'(SETTLE_SAMPLES) - 64'd1) / 64'(SETTLE_SAMPLES));

    typedef enum logic [2:0] {
        IDLE,
        MUL,
        DIV,
        UPD,
        PROD,
        DONE
    } state_t;

    state_t                  state_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [AVG_W-1:0]        avg_reg;
    logic [WEIGHT_W-1:0]     weight_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [1:0]              step_reg;
    logic [AVG_W+THR_W-1:0]  prod_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;

    logic [WEIGHT_W-1:0]     rest;
    logic [MAG_W+WEIGHT_W-1:0] kmag;
    logic [NUM_W-1:0]        rest_avg;
    logic [NUM_W-1:0]        num_next;
    logic [A_HI_W-1:0]       num_part;
    logic [R_LO_W-1:0]       recip_part;
    logic [PP_W-1:0]         part_prod;
    logic [ACC_W-1:0]        acc_term;
    logic [AVG_W-1:0]        quotient;
    logic [AVG_W+THR_W-1:0]  prod_next;
    logic                    crash;
    logic                    out_free;

    always_comb
    begin
        rest      = N_VAL - weight_reg;
        kmag      = (MAG_W+WEIGHT_W)'(weight_reg * mag_reg);
        rest_avg  = NUM_W'(rest * avg_reg);
        num_next  = NUM_W'({kmag, {FRAC_W{1'b0}}}) + rest_avg;
        prod_next = (AVG_W+THR_W)'(avg_reg * threshold);
        crash     = (AVG_W+THR_W)'({mag_reg, 24'd0}) > prod_reg;
        out_free  = !out_valid_reg || !result_stall;

        // divide by N as num_reg * RECIP, one partial product per cycle
        num_part   = step_reg[1] ? num_reg[NUM_W-1 -: A_HI_W]
                                 : A_HI_W'(num_reg[A_LO_W-1:0]);
        recip_part = step_reg[0] ? R_LO_W'(RECIP[RECIP_W-1 -: R_HI_W])
                                 : RECIP[R_LO_W-1:0];
        part_prod  = num_part * recip_part;
        unique case (step_reg)
            2'd0: acc_term = ACC_W'(part_prod);
            2'd1: acc_term = ACC_W'(part_prod) << R_LO_W;
            2'd2: acc_term = ACC_W'(part_prod) << A_LO_W;
            2'd3: acc_term = ACC_W'(part_prod) << (A_LO_W + R_LO_W);
        endcase
        quotient = acc_reg[DIV_SHIFT +: AVG_W];
    end

    assign pop          = (state_reg == IDLE) && !empty;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            avg_reg       <= '0;
            weight_reg    <= N_VAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (!empty)
                    begin
                        mag_reg   <= pop_mag;
                        state_reg <= MUL;
                    end
                end
                MUL:
                begin
                    num_reg   <= num_next;
                    acc_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= DIV;
                end
                DIV:
                begin
                    acc_reg  <= acc_reg + acc_term;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= UPD;
                    end
                end
                UPD:
                begin
                    avg_reg <= quotient;
                    if (weight_reg > WEIGHT_W'(1))
                    begin
                        weight_reg <= weight_reg - WEIGHT_W'(1);
                    end
                    state_reg <= PROD;
                end
                PROD:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= DONE;
                end
                DONE:
                begin
                    if (out_free)
                    begin
                        out_reg.crash_flag    <= crash;
                        out_reg.magnitude     <= mag_reg;
                        out_reg.average_whole <= avg_reg[FRAC_W +: MAG_W];
                        state_reg             <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (weight_reg != '0) && (weight_reg <= N_VAL))
        else $error("weight count out of range");

    a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        avg_reg[AVG_W-1:FRAC_W] <= (AVG_W-FRAC_W)'(MAG_MAX))
        else $error("running average above largest magnitude");

    a_quotient_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == UPD) |->
            ((NUM_W'(quotient) * NUM_W'(N_VAL) <= num_reg)
            && (num_reg - NUM_W'(quotient) * NUM_W'(N_VAL) < NUM_W'(N_VAL))))
        else $error("quotient of divide by N is not the floor");

endmodule

[sv/accel_crash_detector_unit.sv]
`timescale 1ns / 1ps

// Acceleration crash detector.
// Sample channel: sample_valid / sample_stall with one three-axis sample per beat.
// Result channel: result_valid / result_stall; each sample yields exactly one
// result beat with the magnitude, the integer part of the updated running
// average and the crash flag.
// threshold_we / threshold_data write the Q8.8 threshold; write only while idle.
// The front computes sum of squares and an integer square root at one root
// bit per cycle, and takes no new sample until it has pushed the last root.
// A two-entry queue feeds the back, which divides by SETTLE_SAMPLES with a
// reciprocal multiply summed from four partial products and is faster than
// the front, so the front sets the sustained sample rate.
// While the receiver stalls, the result register holds its beat; the back
// finishes the next sample and waits, the queue fills, and the front holds
// its root with sample_stall high until the queue drains.
// Reset clears the running average, sets the weight count to SETTLE_SAMPLES,
// loads the threshold with 282 (about 1.1) and empties the queue.
module accel_crash_detector_unit
    import acd_pkg::*;
#(
    parameter int unsigned SETTLE_SAMPLES = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  sample_t          sample,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             threshold_we,
    input  logic [THR_W-1:0] threshold_data
);

    logic [THR_W-1:0] threshold_reg;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic [MAG_W-1:0] push_mag;
    logic [MAG_W-1:0] pop_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (threshold_we)
        begin
            threshold_reg <= threshold_data;
        end
    end

    acd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .full         (full),
        .push_mag     (push_mag)
    );

    acd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_mag (push_mag),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .pop_mag  (pop_mag)
    );

    acd_back #(
        .SETTLE_SAMPLES (SETTLE_SAMPLES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_mag      (pop_mag),
        .pop          (pop),
        .threshold    (threshold_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
